[hdl/utkn_pkg.sv]
// Package for the UTF-8 text key normaliser: transfer types, register map,
// queue sizing and the punctuation lookup. No dependencies.
package utkn_pkg;

    localparam int ADDR_W  = 3;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [15:0] CAPACITY_RESET = 16'd255;
    localparam logic        REG_CAPACITY   = 1'b0;   // register index, paddr[2]

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        end_of_text;
        logic [15:0] total_bytes;
    } out_item_t;

    // One group of results caused by one input transfer
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      n;
        logic            eot;
        logic [15:0]     base;
    } grp_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic is_punct(input logic [2:0] len, input logic [7:0] a,
                                      input logic [7:0] b, input logic [7:0] c);
        logic r;
        r = 1'b0;
        if (len == SEQ_LEN2)
        begin
            r = (a == 8'hC2) && (b == 8'hB7);
        end
        else if (len == SEQ_LEN3)
        begin
            if (a == 8'hE2 && b == 8'h80)
            begin
                r = c inside {8'h94, 8'h98, 8'h99, 8'h9C, 8'h9D, 8'hA6};
            end
            else if (a == 8'hE3 && b == 8'h80)
            begin
                r = c inside {[8'h80:8'h82], [8'h8A:8'h91]};
            end
            else if (a == 8'hEF && b == 8'hBC)
            begin
                r = c inside {8'h81, 8'h88, 8'h89, [8'h8C:8'h8E], 8'h9A, 8'h9B, 8'h9F};
            end
            else if (a == 8'hEF && b == 8'hBD)
            begin
                r = (c == 8'h9E);
            end
        end
        return r;
    endfunction

endpackage

[hdl/utkn_front.sv]
// Front end: takes text bytes, tracks the open UTF-8 sequence and the output
// count, and emits at most one result group per transfer. Depends on utkn_pkg.
module utkn_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                acc,
    input  utkn_pkg::in_item_t  in_data,
    input  logic [15:0]         capacity,
    output logic                push,
    output utkn_pkg::grp_t      grp
);

    logic [23:0] pend_reg, pend_next;
    logic [2:0]  exp_reg, exp_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] wc_reg, wc_next;
    logic        stop_reg, stop_next;

    logic [7:0] b, lc;
    logic       eot, fresh;
    logic [7:0] s0, s1, s2, s3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            exp_reg  <= utkn_pkg::SEQ_NONE;
            cnt_reg  <= '0;
            wc_reg   <= '0;
            stop_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            exp_reg  <= exp_next;
            cnt_reg  <= cnt_next;
            wc_reg   <= wc_next;
            stop_reg <= stop_next;
        end
    end

    // order the held bytes plus the new one, lead first
    always_comb
    begin
        s0 = pend_reg[7:0];
        s1 = b;
        s2 = 8'h00;
        s3 = 8'h00;
        case (cnt_reg)
            2'd2:
            begin
                s0 = pend_reg[15:8];
                s1 = pend_reg[7:0];
                s2 = b;
            end
            2'd3:
            begin
                s0 = pend_reg[23:16];
                s1 = pend_reg[15:8];
                s2 = pend_reg[7:0];
                s3 = b;
            end
            default:
            begin
                s0 = pend_reg[7:0];
                s1 = b;
            end
        endcase
    end

    always_comb
    begin
        b         = in_data.in_byte;
        eot       = (b == 8'h00) || in_data.last;
        lc        = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
        fresh     = 1'b1;
        pend_next = pend_reg;
        exp_next  = exp_reg;
        cnt_next  = cnt_reg;
        wc_next   = wc_reg;
        stop_next = stop_reg;
        grp.bytes = '0;
        grp.n     = 3'd0;
        grp.eot   = eot;
        grp.base  = wc_reg;

        if (acc)
        begin
            if (b != 8'h00 && !stop_reg)
            begin
                if (exp_reg != utkn_pkg::SEQ_NONE)
                begin
                    if ((b & utkn_pkg::CONT_MASK) == utkn_pkg::CONT_CODE)
                    begin
                        fresh = 1'b0;
                        if ({1'b0, cnt_reg} + 3'd1 < exp_reg)
                        begin
                            pend_next = {pend_reg[15:0], b};
                            cnt_next  = cnt_reg + 2'd1;
                        end
                        else
                        begin
                            pend_next = '0;
                            exp_next  = utkn_pkg::SEQ_NONE;
                            cnt_next  = '0;
                            if (!utkn_pkg::is_punct(exp_reg, s0, s1, s2))
                            begin
                                if ({1'b0, wc_reg} + 17'(exp_reg) > {1'b0, capacity})
                                begin
                                    stop_next = 1'b1;
                                end
                                else
                                begin
                                    grp.bytes = {s3, s2, s1, s0};
                                    grp.n     = exp_reg;
                                    wc_next   = wc_reg + 16'(exp_reg);
                                end
                            end
                        end
                    end
                    else
                    begin
                        pend_next = '0;
                        exp_next  = utkn_pkg::SEQ_NONE;
                        cnt_next  = '0;
                    end
                end
                if (fresh)
                begin
                    if (wc_reg >= capacity)
                    begin
                        stop_next = 1'b1;
                    end
                    else if (!b[7])
                    begin
                        if ((lc >= 8'h61 && lc <= 8'h7A) || (lc >= 8'h30 && lc <= 8'h39))
                        begin
                            grp.bytes[0] = lc;
                            grp.n        = 3'd1;
                            wc_next      = wc_reg + 16'd1;
                        end
                    end
                    else if ((b & utkn_pkg::LEAD2_MASK) == utkn_pkg::LEAD2_CODE)
                    begin
                        pend_next = {16'h0000, b};
                        cnt_next  = 2'd1;
                        exp_next  = utkn_pkg::SEQ_LEN2;
                    end
                    else if ((b & utkn_pkg::LEAD3_MASK) == utkn_pkg::LEAD3_CODE)
                    begin
                        pend_next = {16'h0000, b};
                        cnt_next  = 2'd1;
                        exp_next  = utkn_pkg::SEQ_LEN3;
                    end
                    else if ((b & utkn_pkg::LEAD4_MASK) == utkn_pkg::LEAD4_CODE)
                    begin
                        pend_next = {16'h0000, b};
                        cnt_next  = 2'd1;
                        exp_next  = utkn_pkg::SEQ_LEN4;
                    end
                end
            end
            if (eot)
            begin
                pend_next = '0;
                exp_next  = utkn_pkg::SEQ_NONE;
                cnt_next  = '0;
                wc_next   = '0;
                stop_next = 1'b0;
            end
        end
        push = acc && ((grp.n != 3'd0) || eot);
    end

endmodule

[hdl/utkn_queue.sv]
// Short group queue between front and back ends. Depends on utkn_pkg.
module utkn_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  utkn_pkg::grp_t        wr_grp,
    input  logic                  pop,
    output utkn_pkg::grp_t        head,
    output utkn_pkg::q_status_t   status
);

    utkn_pkg::grp_t                    mem_reg [utkn_pkg::QDEPTH];
    logic [utkn_pkg::QPTR_W-1:0]       wp_reg, wp_next;
    logic [utkn_pkg::QPTR_W-1:0]       rp_reg, rp_next;
    logic [utkn_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;

    function automatic logic [utkn_pkg::QCNT_W-1:0] QCNT_ONE(input logic v);
        return {{(utkn_pkg::QCNT_W-1){1'b0}}, v};
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr_grp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_comb
    begin
        wp_next  = push ? wp_reg + utkn_pkg::QPTR_W'(1) : wp_reg;
        rp_next  = pop ? rp_reg + utkn_pkg::QPTR_W'(1) : rp_reg;
        cnt_next = cnt_reg + QCNT_ONE(push) - QCNT_ONE(pop);
        head     = mem_reg[rp_reg];
        status.full  = (cnt_reg == utkn_pkg::QCNT_W'(utkn_pkg::QDEPTH));
        status.empty = (cnt_reg == '0);
    end

endmodule

[hdl/utkn_back.sv]
// Back end: splits result groups into single result transfers behind an
// output register. Depends on utkn_pkg.
module utkn_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  utkn_pkg::grp_t        head,
    input  logic                  empty,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output utkn_pkg::out_item_t   out_data
);

    logic                 ov_reg, ov_next;
    utkn_pkg::out_item_t  od_reg, od_next;
    logic [1:0]           idx_reg, idx_next;
    logic                 take, last_piece;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg  <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            ov_reg  <= ov_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg <= od_next;
    end

    always_comb
    begin
        take       = !empty && (!ov_reg || !out_stall);
        last_piece = (head.n == 3'd0) || ({1'b0, idx_reg} + 3'd1 == head.n);
        od_next    = od_reg;
        if (take)
        begin
            if (head.n == 3'd0)
            begin
                od_next.out_byte    = 8'h00;
                od_next.byte_valid  = 1'b0;
                od_next.total_bytes = head.base;
            end
            else
            begin
                od_next.out_byte    = head.bytes[idx_reg];
                od_next.byte_valid  = 1'b1;
                od_next.total_bytes = head.base + 16'(idx_reg) + 16'd1;
            end
            od_next.end_of_text = head.eot && last_piece;
        end
        if (take)
        begin
            ov_next = 1'b1;
        end
        else if (!out_stall)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
        if (take)
        begin
            idx_next = last_piece ? 2'd0 : idx_reg + 2'd1;
        end
        else
        begin
            idx_next = idx_reg;
        end
        pop       = take && last_piece;
        out_valid = ov_reg;
        out_data  = od_reg;
    end

endmodule

[hdl/utkn_top.sv]
// UTF-8 text key normaliser, top level: APB capacity register, front end,
// group queue and back end. Depends on utkn_pkg, utkn_front, utkn_queue, utkn_back.
//
// One text byte is taken per cycle while the four-entry group queue has room;
// each byte yields zero to four result transfers, and the back end sends one
// result per cycle while out_stall is low, so a text whose bytes each give at
// most one result runs at one byte per cycle. A kept multibyte character gives one
// result per byte. The capacity register (address 0, reset 255) is to be written
// by the user only while the block is idle; the block itself does not enforce this.
module utf8_text_key_normalizer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [utkn_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  utkn_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output utkn_pkg::out_item_t           out_data
);

    logic [15:0]          cap_reg;
    logic                 acc, push, pop;
    utkn_pkg::grp_t       wr_grp, head;
    utkn_pkg::q_status_t  qs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= utkn_pkg::CAPACITY_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == utkn_pkg::REG_CAPACITY)
        begin
            cap_reg <= pwdata[15:0];
        end
    end

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == utkn_pkg::REG_CAPACITY) ? {16'h0000, cap_reg} : 32'h0;
    assign in_stall = qs.full;
    assign acc      = in_valid && !qs.full;

    utkn_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .acc      (acc),
        .in_data  (in_data),
        .capacity (cap_reg),
        .push     (push),
        .grp      (wr_grp)
    );

    utkn_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_grp (wr_grp),
        .pop    (pop),
        .head   (head),
        .status (qs)
    );

    utkn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (qs.empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        qs.full |-> !push)
        else $error("group queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qs.empty)
        else $error("group queue underflow");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.byte_valid |-> out_data.total_bytes != 16'd0)
        else $error("emitted byte with zero running count");

    a_end_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.byte_valid |-> out_data.end_of_text)
        else $error("empty result transfer without end of text");

endmodule

[tb/utf8_text_key_normalizer_top_test.sv]
// Self-checking testbench for utf8_text_key_normalizer_top: directed and random texts,
// an in-bench key normaliser predicting each result, random input gaps and random output stalls.
// Depends on utkn_pkg and the RTL under hdl/.
module utf8_text_key_normalizer_top_test;

    localparam logic [utkn_pkg::ADDR_W-1:0] CAP_ADDR = {utkn_pkg::REG_CAPACITY, 2'b00};
    localparam int unsigned       CYCLE_LIMIT   = 300000;
    localparam int                SETTLE_CYCLES = 24;
    localparam int                ITEM_TARGET   = 380;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [utkn_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        in_valid;
    logic                        in_stall;
    utkn_pkg::in_item_t          in_data;
    logic                        out_valid;
    logic                        out_stall;
    utkn_pkg::out_item_t         out_data;

    // normaliser state as the block should hold it
    logic [15:0]       cap_limit;
    logic [23:0]       seq_buf;
    int                seq_len;
    int                seq_have;
    logic [15:0]       out_count;
    logic              halted;

    utkn_pkg::out_item_t key_q[$];
    utkn_pkg::out_item_t key_want;
    logic [7:0]        text_q[$];
    int                sent_count = 0;
    int                mismatch_count = 0;
    int                hold_request = 0;
    int unsigned       cycle_count = 0;
    logic              tx_steady = 1'b0;
    logic              rx_steady = 1'b0;

    utf8_text_key_normalizer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
    endtask

    function automatic logic is_key_punct(input int len, input logic [31:0] word);
        if (len == 2)
        begin
            return word[15:0] == 16'hC2B7;
        end
        if (len != 3)
        begin
            return 1'b0;
        end
        return word[23:0] inside {24'hE28094, 24'hE28098, 24'hE28099, 24'hE2809C,
            24'hE2809D, 24'hE280A6, [24'hE38080:24'hE38082], [24'hE3808A:24'hE38091],
            24'hEFBC81, 24'hEFBC88, 24'hEFBC89, [24'hEFBC8C:24'hEFBC8E], 24'hEFBC9A,
            24'hEFBC9B, 24'hEFBC9F, 24'hEFBD9E};
    endfunction

    // Works out the results one accepted byte causes and queues them
    task automatic normalize_byte(input logic [7:0] b, input logic lst);
        utkn_pkg::out_item_t res [4];
        logic [31:0] word;
        logic [7:0]  c;
        int          n;
        int          len;
        int          i;
        logic        fresh;
        n = 0;
        fresh = 1'b1;
        if (b != 8'h00 && !halted)
        begin
            if (seq_len != 0)
            begin
                if ((b & utkn_pkg::CONT_MASK) == utkn_pkg::CONT_CODE)
                begin
                    fresh = 1'b0;
                    if (seq_have + 1 < seq_len)
                    begin
                        seq_buf = {seq_buf[15:0], b};
                        seq_have++;
                    end
                    else
                    begin
                        len = seq_have + 1;
                        word = {seq_buf, b};
                        seq_buf = '0;
                        seq_len = 0;
                        seq_have = 0;
                        if (!is_key_punct(len, word))
                        begin
                            if (int'(out_count) + len > int'(cap_limit))
                            begin
                                halted = 1'b1;
                            end
                            else
                            begin
                                for (i = len - 1; i >= 0; i--)
                                begin
                                    out_count++;
                                    res[n] = '{word[8*i +: 8], 1'b1, 1'b0, out_count};
                                    n++;
                                end
                            end
                        end
                    end
                end
                else
                begin
                    seq_buf = '0;
                    seq_len = 0;
                    seq_have = 0;
                end
            end
            if (fresh)
            begin
                if (out_count >= cap_limit)
                begin
                    halted = 1'b1;
                end
                else if (b < 8'h80)
                begin
                    c = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
                    if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39))
                    begin
                        out_count++;
                        res[n] = '{c, 1'b1, 1'b0, out_count};
                        n++;
                    end
                end
                else if ((b & utkn_pkg::LEAD2_MASK) == utkn_pkg::LEAD2_CODE)
                begin
                    seq_buf = {16'h0000, b};
                    seq_have = 1;
                    seq_len = 2;
                end
                else if ((b & utkn_pkg::LEAD3_MASK) == utkn_pkg::LEAD3_CODE)
                begin
                    seq_buf = {16'h0000, b};
                    seq_have = 1;
                    seq_len = 3;
                end
                else if ((b & utkn_pkg::LEAD4_MASK) == utkn_pkg::LEAD4_CODE)
                begin
                    seq_buf = {16'h0000, b};
                    seq_have = 1;
                    seq_len = 4;
                end
            end
        end
        if (b == 8'h00 || lst)
        begin
            if (n > 0)
            begin
                res[n-1].end_of_text = 1'b1;
            end
            else
            begin
                res[0] = '{8'h00, 1'b0, 1'b1, out_count};
                n = 1;
            end
            seq_buf = '0;
            seq_len = 0;
            seq_have = 0;
            out_count = '0;
            halted = 1'b0;
        end
        for (i = 0; i < n; i++)
        begin
            key_q.push_back(res[i]);
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (key_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result byte %02h valid %0d end %0d total %0d",
                    out_data.out_byte, out_data.byte_valid, out_data.end_of_text,
                    out_data.total_bytes));
            end
            else
            begin
                key_want = key_q.pop_front();
                if (out_data.out_byte !== key_want.out_byte ||
                    out_data.byte_valid !== key_want.byte_valid ||
                    out_data.end_of_text !== key_want.end_of_text ||
                    out_data.total_bytes !== key_want.total_bytes)
                begin
                    report_mismatch($sformatf(
                        "want byte %02h valid %0d end %0d total %0d, got %02h %0d %0d %0d",
                        key_want.out_byte, key_want.byte_valid, key_want.end_of_text,
                        key_want.total_bytes, out_data.out_byte, out_data.byte_valid,
                        out_data.end_of_text, out_data.total_bytes));
                end
            end
        end
    end

    // Receiver: random wait after each transfer, or a long hold-off on request
    initial
    begin
        int wait_n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                wait_n = hold_request;
                hold_request = 0;
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (out_valid && !out_stall)
            begin
                wait_n = rx_steady ? 0 : $urandom_range(0, 16);
                if (wait_n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (wait_n) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic lst);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{in_byte: b, last: lst};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        normalize_byte(b, lst);
        sent_count++;
    endtask

    // Sends text_q; ends on last with the final byte, or with a zero byte
    task automatic send_text(input logic end_with_last);
        int k;
        for (k = 0; k < text_q.size(); k++)
        begin
            send_item(text_q[k], end_with_last && (k == text_q.size() - 1));
        end
        if (!end_with_last || text_q.size() == 0)
        begin
            send_item(8'h00, 1'($urandom_range(0, 1)));
        end
        text_q.delete();
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (key_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        wait_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CAP_ADDR;
        pwdata <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        cap_limit = value;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata[15:0] !== value)
        begin
            report_mismatch($sformatf("capacity readback: want %0d, got %0d",
                value, prdata[15:0]));
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_random_char();
        int          pick;
        logic [23:0] code;
        pick = $urandom_range(0, 19);
        if (pick < 6)
        begin
            text_q.push_back(8'(8'h61 + $urandom_range(0, 25)));
        end
        else if (pick < 8)
        begin
            text_q.push_back(8'(8'h41 + $urandom_range(0, 25)));
        end
        else if (pick < 9)
        begin
            text_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
        end
        else if (pick < 11)
        begin
            text_q.push_back(8'($urandom_range(1, 127)));
        end
        else if (pick < 13)
        begin
            text_q.push_back(8'(8'hC0 + $urandom_range(0, 31)));
            text_q.push_back(8'(8'h80 | $urandom_range(0, 63)));
        end
        else if (pick < 15)
        begin
            text_q.push_back(8'(8'hE0 + $urandom_range(0, 15)));
            repeat (2) text_q.push_back(8'(8'h80 | $urandom_range(0, 63)));
        end
        else if (pick < 16)
        begin
            text_q.push_back(8'(8'hF0 + $urandom_range(0, 7)));
            repeat (3) text_q.push_back(8'(8'h80 | $urandom_range(0, 63)));
        end
        else if (pick < 18)
        begin
            case ($urandom_range(0, 7))
                0:       code = 24'hE28094;
                1:       code = 24'hE280A6;
                2:       code = 24'hE38082;
                3:       code = 24'hE3808A;
                4:       code = 24'hEFBC81;
                5:       code = 24'hEFBC9F;
                6:       code = 24'hEFBD9E;
                default: code = 24'h00C2B7;
            endcase
            if (code[23:16] != 8'h00)
            begin
                text_q.push_back(code[23:16]);
            end
            text_q.push_back(code[15:8]);
            text_q.push_back(code[7:0]);
        end
        else if (pick < 19)
        begin
            // lead with too few continuation bytes
            text_q.push_back(8'(8'hE0 + $urandom_range(0, 23)));
            repeat ($urandom_range(0, 1)) text_q.push_back(8'(8'h80 | $urandom_range(0, 63)));
        end
        else
        begin
            text_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_ascii_folding();
        text_q = '{8'h41, 8'h7A, 8'h30, 8'h39, 8'h21};
        send_text(1'b1);
        text_q = '{8'h51};
        send_text(1'b1);
        send_text(1'b0);
    endtask

    task automatic test_multibyte_sequences();
        text_q = '{8'hC3, 8'hA9, 8'hC2, 8'hB7, 8'hE2, 8'h80, 8'h94,
                   8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80, 8'hF8, 8'hC0, 8'h80,
                   8'hE4, 8'hB8, 8'h41, 8'hEF, 8'hBD, 8'h9E, 8'hC3};
        send_text(1'b1);
    endtask

    task automatic test_capacity_limits();
        write_capacity(16'd1);
        text_q = '{8'h61, 8'h62};
        send_text(1'b0);
        text_q = '{8'hC3, 8'hA9, 8'h61};
        send_text(1'b0);
        write_capacity(16'd2);
        text_q = '{8'h78, 8'hE4, 8'hB8, 8'hAD, 8'h79};
        send_text(1'b0);
        write_capacity(16'hFFFF);
    endtask

    task automatic test_backpressure();
        int k;
        write_capacity(16'hFFFF);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        hold_request = 80;
        for (k = 0; k < 10; k++)
        begin
            text_q.push_back(8'h6B);
            text_q.push_back(8'hF0);
            text_q.push_back(8'h9F);
            text_q.push_back(8'h98);
            text_q.push_back(8'(8'h80 + k));
        end
        send_text(1'b0);
        // hold the sender until every pending result is out
        wait_drained();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_random_texts();
        int t;
        int nchar;
        while (sent_count < ITEM_TARGET)
        begin
            case ($urandom_range(0, 5))
                0:       write_capacity(16'd1);
                1:       write_capacity(16'd3);
                2:       write_capacity(16'hFFFF);
                3:       write_capacity(16'd255);
                default: write_capacity(16'($urandom_range(2, 40)));
            endcase
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            for (t = 0; t < 4; t++)
            begin
                nchar = $urandom_range(1, 12);
                repeat (nchar) push_random_char();
                send_text(1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        in_data <= '0;
        cap_limit = utkn_pkg::CAPACITY_RESET;
        seq_buf = '0;
        seq_len = 0;
        seq_have = 0;
        out_count = '0;
        halted = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ascii_folding();
        test_multibyte_sequences();
        test_capacity_limits();
        test_backpressure();
        test_random_texts();

        wait_drained();
        if (mismatch_count == 0 && key_q.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
